FILE: src/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

  localparam int TfineOffset = 128000;
  localparam int PressFull   = 1048576;
  localparam int PressScale  = 3125;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegT1T2 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegT3P1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegP2P3 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegP4P5 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegP6P7 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegP8P9 = 3'd5;

  localparam int FrontStages = 8;
  localparam int DivStages   = 64;
  localparam int BackStages  = 4;
  localparam int NumStages   = FrontStages + DivStages + 1 + BackStages;
  localparam int DivBase     = FrontStages;
  localparam int BackBase    = FrontStages + DivStages + 1;

endpackage

`default_nettype wire

FILE: src/pressure_temp_compensation_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer pressure compensation for a 20-bit barometric sensor. Each accepted
// word of raw pressure and temperature yields one word of pressure in Pa x 256
// (low 32 bits) and a status bit that is set, with pressure zero, when the
// divisor term is zero. The datapath is a fixed pipeline of 78 register stages:
// eight for the temperature and coefficient terms, a set-up stage and a
// 64-stage restoring divider (one quotient bit a stage), and five for the
// correction terms and output.
// A word is accepted every cycle unless back-pressure holds the output while the last stage is full.
// Calibration registers are written through the config port; the user must do so
// only while no word is in flight, as the block itself does not enforce this.

module pressure_temp_compensation_core
  import ptc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [19:0]        raw_pressure_i,
  input  wire logic [19:0]        raw_temperature_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             pressure_q24_8_o,
  output logic                    status_o
);

  localparam int Last = NumStages - 1;

  logic [31:0] cal_t1_t2_q, cal_t3_p1_q, cal_p2_p3_q, cal_p4_p5_q, cal_p6_p7_q, cal_p8_p9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t1_t2_q <= '0;
      cal_t3_p1_q <= '0;
      cal_p2_p3_q <= '0;
      cal_p4_p5_q <= '0;
      cal_p6_p7_q <= '0;
      cal_p8_p9_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegT1T2: cal_t1_t2_q <= cfg_data_i;
        RegT3P1: cal_t3_p1_q <= cfg_data_i;
        RegP2P3: cal_p2_p3_q <= cfg_data_i;
        RegP4P5: cal_p4_p5_q <= cfg_data_i;
        RegP6P7: cal_p6_p7_q <= cfg_data_i;
        RegP8P9: cal_p8_p9_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic        [15:0] t1, c1;
  logic        [31:0] t2x, t3x;
  logic signed [15:0] c2, c3, c4, c5, c6, c7, c8, c9;

  assign t1  = cal_t1_t2_q[15:0];
  assign t2x = {{16{cal_t1_t2_q[31]}}, cal_t1_t2_q[31:16]};
  assign t3x = {{16{cal_t3_p1_q[15]}}, cal_t3_p1_q[15:0]};
  assign c1  = cal_t3_p1_q[31:16];
  assign c2  = $signed(cal_p2_p3_q[15:0]);
  assign c3  = $signed(cal_p2_p3_q[31:16]);
  assign c4  = $signed(cal_p4_p5_q[15:0]);
  assign c5  = $signed(cal_p4_p5_q[31:16]);
  assign c6  = $signed(cal_p6_p7_q[15:0]);
  assign c7  = $signed(cal_p6_p7_q[31:16]);
  assign c8  = $signed(cal_p8_p9_q[15:0]);
  assign c9  = $signed(cal_p8_p9_q[31:16]);

  // pipeline control
  logic [NumStages-1:0] vld_q;
  logic                 out_valid_q;
  logic                 out_load, en, in_fire;

  assign out_load   = !out_valid_q || out_ready_i;
  assign en         = out_load || !vld_q[Last];
  assign in_ready_o = en;
  assign in_fire    = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[Last-1:0], in_fire};
      end
      if (out_load) begin
        out_valid_q <= vld_q[Last];
      end
    end
  end

  // temperature path
  logic [31:0] da, db;
  assign da = {15'd0, raw_temperature_i[19:3]} - {15'd0, t1, 1'b0};
  assign db = {16'd0, raw_temperature_i[19:4]} - {16'd0, t1};

  logic        [31:0] m1_q, dd_q, v1_q, m3_q, tfine;
  logic        [19:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [33:0] ta_q;
  logic signed [63:0] aa_q, ac5_q, ac2_q, b1_q, aa3_q, ac5r_q, ac2r_q, b_q, a2_q, a3_q;
  logic        [63:0] n0_q, n_q;
  logic        [20:0] pd;
  logic        [31:0] dv_d, dv_q;
  logic               st_q;

  assign tfine = v1_q + 32'($signed(m3_q) >>> 14);
  assign pd    = 21'(PressFull) - {1'b0, p6_q};
  assign dv_d  = 32'(a3_q >>> 33);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q   <= da * t2x;
      dd_q   <= db * db;
      p1_q   <= raw_pressure_i;
      v1_q   <= 32'($signed(m1_q) >>> 11);
      m3_q   <= 32'($signed(dd_q) >>> 12) * t3x;
      p2_q   <= p1_q;
      ta_q   <= 34'($signed(tfine)) - 34'(TfineOffset);
      p3_q   <= p2_q;
      aa_q   <= 64'(ta_q * ta_q);
      ac5_q  <= 64'(ta_q * c5);
      ac2_q  <= 64'(ta_q * c2);
      p4_q   <= p3_q;
      b1_q   <= 64'(aa_q * c6);
      aa3_q  <= 64'(aa_q * c3);
      ac5r_q <= ac5_q;
      ac2r_q <= ac2_q;
      p5_q   <= p4_q;
      b_q    <= b1_q + (ac5r_q <<< 17) + (64'(c4) <<< 35);
      a2_q   <= (aa3_q >>> 8) + (ac2r_q <<< 12);
      p6_q   <= p5_q;
      a3_q   <= 64'((a2_q + (64'sd1 <<< 47)) * $signed({1'b0, c1}));
      n0_q   <= (64'(pd) << 31) - $unsigned(b_q);
      dv_q   <= dv_d;
      n_q    <= n0_q * 64'(PressScale);
      st_q   <= (dv_d == '0);
    end
  end

  // restoring divider, one quotient bit a stage
  logic [63:0] dx_q  [DivStages+1];
  logic [31:0] rem_q [DivStages+1];
  logic [31:0] dm_q  [DivStages+1];
  logic        qn_q  [DivStages+1];
  logic        dst_q [DivStages+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q[0]  <= n_q[63] ? (64'd0 - n_q) : n_q;
      rem_q[0] <= '0;
      dm_q[0]  <= dv_q[31] ? (32'd0 - dv_q) : dv_q;
      qn_q[0]  <= n_q[63] ^ dv_q[31];
      dst_q[0] <= st_q;
    end
  end

  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    logic [31:0] trial;
    logic        ge;
    assign trial = {rem_q[k-1][30:0], dx_q[k-1][63]};
    assign ge    = trial >= dm_q[k-1];
    always_ff @(posedge clk_i) begin
      if (en) begin
        dx_q[k]  <= {dx_q[k-1][62:0], ge};
        rem_q[k] <= ge ? (trial - dm_q[k-1]) : trial;
        dm_q[k]  <= dm_q[k-1];
        qn_q[k]  <= qn_q[k-1];
        dst_q[k] <= dst_q[k-1];
      end
    end
  end

  // correction terms
  logic signed [63:0] q_q, ps, ps_q, c9ps_q, c8p_q, q2_q, c8p3_q, q3_q, prod, s_q;
  logic        [63:0] ll_q;
  logic        [31:0] cross_q;
  logic               bst1_q, bst2_q, bst3_q, bst4_q;
  logic        [31:0] pres_q;
  logic               status_q;

  assign ps   = q_q >>> 13;
  assign prod = $signed(ll_q + {cross_q, 32'd0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q     <= qn_q[DivStages] ? $signed(64'd0 - dx_q[DivStages]) : $signed(dx_q[DivStages]);
      bst1_q  <= dst_q[DivStages];
      ps_q    <= ps;
      c9ps_q  <= 64'(c9 * ps);
      c8p_q   <= 64'(c8 * q_q);
      q2_q    <= q_q;
      bst2_q  <= bst1_q;
      ll_q    <= c9ps_q[31:0] * ps_q[31:0];
      cross_q <= c9ps_q[31:0] * ps_q[63:32] + c9ps_q[63:32] * ps_q[31:0];
      c8p3_q  <= c8p_q;
      q3_q    <= q2_q;
      bst3_q  <= bst2_q;
      s_q     <= q3_q + (prod >>> 25) + (c8p3_q >>> 19);
      bst4_q  <= bst3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pres_q   <= bst4_q ? 32'd0 : (32'(s_q >>> 8) + (32'(c7) << 4));
      status_q <= bst4_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pressure_q24_8_o = pres_q;
  assign status_o         = status_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> pressure_q24_8_o == '0)
    else $error("error word carries nonzero pressure");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && vld_q[Last] |-> !in_ready_o)
    else $error("input taken with full blocked pipeline");

  a_fire_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word not in first stage");

endmodule

`default_nettype wire

FILE: tb/pressure_temp_compensation_core_tb.sv
`timescale 1ns / 1ps

module pressure_temp_compensation_core_tb
  import ptc_pkg::*;
();

  localparam int NumRegs = 6;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;
  localparam int CycleLimit = 600000;
  localparam int ClkHalf = 6;

  typedef struct packed {
    logic [31:0] pressure;
    logic        status;
  } comp_word_t;

  class comp_scoreboard;
    logic [31:0] cal[NumRegs];
    comp_word_t  pending[$];
    int          errors;

    function new();
      foreach (cal[i]) cal[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
      if (idx < NumRegs) cal[idx] = v;
    endfunction

    function logic [31:0] asr32(logic [31:0] x, int s);
      return $signed(x) >>> s;
    endfunction

    function logic [63:0] asr64(logic [63:0] x, int s);
      return $signed(x) >>> s;
    endfunction

    function logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    function logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
      logic [63:0] nm, dm, q;
      nm = n[63] ? -n : n;
      dm = d[63] ? -d : d;
      q = nm / dm;
      return (n[63] != d[63]) ? -q : q;
    endfunction

    function void note_reading(logic [19:0] rp, logic [19:0] rt);
      logic [31:0] t1, t2, t3, da, db, v1, v2, tfine, adc_t;
      logic [63:0] c1, c2, c3, c4, c5, c6, c7, c8, c9;
      logic [63:0] a, b, dv, p, ps, r1, r2;
      comp_word_t w;
      adc_t = {12'd0, rt};
      t1 = {16'd0, cal[RegT1T2][15:0]};
      t2 = {{16{cal[RegT1T2][31]}}, cal[RegT1T2][31:16]};
      t3 = {{16{cal[RegT3P1][15]}}, cal[RegT3P1][15:0]};
      c1 = {48'd0, cal[RegT3P1][31:16]};
      c2 = sx16(cal[RegP2P3][15:0]);
      c3 = sx16(cal[RegP2P3][31:16]);
      c4 = sx16(cal[RegP4P5][15:0]);
      c5 = sx16(cal[RegP4P5][31:16]);
      c6 = sx16(cal[RegP6P7][15:0]);
      c7 = sx16(cal[RegP6P7][31:16]);
      c8 = sx16(cal[RegP8P9][15:0]);
      c9 = sx16(cal[RegP8P9][31:16]);
      da = (adc_t >> 3) - (t1 << 1);
      v1 = asr32(da * t2, 11);
      db = (adc_t >> 4) - t1;
      v2 = asr32(asr32(db * db, 12) * t3, 14);
      tfine = v1 + v2;
      a = {{32{tfine[31]}}, tfine} - 64'(TfineOffset);
      b = a * a * c6;
      b = b + ((a * c5) << 17);
      b = b + (c4 << 35);
      dv = asr64(a * a * c3, 8) + ((a * c2) << 12);
      dv = asr64(((64'd1 << 47) + dv) * c1, 33);
      if (dv == 64'd0) begin
        w.pressure = '0;
        w.status = 1'b1;
      end else begin
        p = 64'(PressFull) - {44'd0, rp};
        p = sdiv(((p << 31) - b) * 64'(PressScale), dv);
        ps = asr64(p, 13);
        r1 = asr64(c9 * ps * ps, 25);
        r2 = asr64(c8 * p, 19);
        p = asr64(p + r1 + r2, 8) + (c7 << 4);
        w.pressure = p[31:0];
        w.status = 1'b0;
      end
      pending.push_back(w);
    endfunction

    function void check_word(logic [31:0] p, logic s);
      comp_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected word: pressure %h status %b", p, s);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (p !== w.pressure) begin
        $error("pressure_q24_8: expected %h, actual %h", w.pressure, p);
        errors++;
      end
      if (s !== w.status) begin
        $error("status: expected %b, actual %b", w.status, s);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [19:0]        raw_pressure_i = '0;
  logic [19:0]        raw_temperature_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [31:0]        pressure_q24_8_o;
  logic               status_o;

  comp_scoreboard sb = new();
  int cycles = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_count = 0;

  logic [31:0] typical_cal[NumRegs] = '{
    {16'd26435, 16'd27504},
    {16'd36477, 16'hFC18},
    {16'd3024, 16'hD643},
    {16'd140, 16'd2855},
    {16'd15500, 16'hFFF9},
    {16'd6000, 16'hC6F8}
  };

  pressure_temp_compensation_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .raw_pressure_i,
    .raw_temperature_i,
    .out_valid_o,
    .out_ready_i,
    .pressure_q24_8_o,
    .status_o
  );

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(pressure_q24_8_o, status_o);
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rx_count <= rx_count + 1;
      if (rx_count % 50 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic write_cal(logic [CfgIdxW-1:0] idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (NumStages + 4) @(negedge clk_i);
  endtask

  task automatic load_cal(logic [31:0] c[NumRegs]);
    wait_idle();
    write_cal(RegT1T2, c[0]);
    write_cal(RegT3P1, c[1]);
    write_cal(RegP2P3, c[2]);
    write_cal(RegP4P5, c[3]);
    write_cal(RegP6P7, c[4]);
    write_cal(RegP8P9, c[5]);
  endtask

  task automatic send_reading(logic [19:0] rp, logic [19:0] rt);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    raw_pressure_i = rp;
    raw_temperature_i = rt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_reading(rp, rt);
  endtask

  task automatic send_directed();
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'd0);
    send_reading(20'd415148, 20'd519888);
    send_reading(20'h80000, 20'h80000);
  endtask

  task automatic send_random(int n);
    int left, burst, gap;
    logic [19:0] rp, rt;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && left > 0; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          rp = 20'($urandom_range(300000, 500000));
          rt = 20'($urandom_range(450000, 600000));
        end else begin
          rp = 20'($urandom);
          rt = 20'($urandom);
        end
        send_reading(rp, rt);
        left--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    logic [31:0] c[NumRegs];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero calibration: divisor term zero
    send_directed();

    load_cal(typical_cal);
    send_directed();
    send_reading(20'd300000, 20'd500000);

    foreach (c[i]) c[i] = 32'hFFFFFFFF;
    load_cal(c);
    send_directed();
    wait_idle();
    write_cal(RegSpare, 32'h12345678);
    write_cal(RegSpareLo, 32'h0);
    send_directed();

    foreach (c[i]) c[i] = 32'h80008000;
    load_cal(c);
    send_directed();

    for (int ph = 0; ph < 8; ph++) begin
      foreach (c[i]) begin
        if (ph % 2 == 0) c[i] = typical_cal[i] ^ ($urandom & 32'h00FF00FF);
        else c[i] = $urandom;
      end
      if (ph == 5) c[1][31:16] = 16'd0;
      load_cal(c);
      if (ph == 2) hold_left = 500;
      send_random(200);
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (NumStages + 10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
